FILE: rtl/cid_pkg.sv
package cid_pkg;

    localparam int ADDR_BITS_DEF = 19;
    localparam int FRAC_BITS_DEF = 16;

    localparam int SAMPLE_W = 24;
    localparam int SEC_W    = 24;
    localparam int RATE_W   = 18;
    localparam int BLEN_W   = 13;
    localparam int CFG_IDX_W = 1;
    localparam int SEC_FRAC = 20;

    localparam logic [RATE_W-1:0] RATE_RESET   = 18'd48000;
    localparam logic [BLEN_W-1:0] BLEN_RESET   = 13'd64;
    localparam logic [SEC_W-1:0]  REQ_RESET    = 24'h100000;

    localparam logic [CFG_IDX_W-1:0] CFG_SAMPLE_RATE  = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_BLOCK_LENGTH = 1'b1;

    typedef struct packed {
        logic busy;
        logic done;
    } div_stat_t;

endpackage

FILE: rtl/cid_div.sv
module cid_div
    import cid_pkg::*;
#(
    parameter int DW = ADDR_BITS_DEF + FRAC_BITS_DEF + 1
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    input  logic [DW-1:0]     dividend,
    input  logic [BLEN_W-1:0] divisor,
    output logic [DW-1:0]     quotient,
    output div_stat_t         stat
);

    localparam int CW = $clog2(DW + 1);

    logic [BLEN_W-1:0] rem_reg, rem_next;
    logic [DW-1:0]     quo_reg, quo_next;
    logic [BLEN_W-1:0] dvs_reg;
    logic [CW-1:0]     cnt_reg;
    logic              busy_reg;
    logic              done_reg;
    logic [BLEN_W:0]   trial;

    // one quotient bit a cycle, restoring
    always_comb
    begin
        trial = {rem_reg, quo_reg[DW-1]};
        if (trial >= {1'b0, dvs_reg})
        begin
            rem_next = BLEN_W'(trial - {1'b0, dvs_reg});
            quo_next = {quo_reg[DW-2:0], 1'b1};
        end
        else
        begin
            rem_next = trial[BLEN_W-1:0];
            quo_next = {quo_reg[DW-2:0], 1'b0};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= CW'(DW);
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == CW'(1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rem_reg <= '0;
            quo_reg <= dividend;
            dvs_reg <= divisor;
        end
        else if (busy_reg)
        begin
            rem_reg <= rem_next;
            quo_reg <= quo_next;
        end
    end

    assign quotient  = quo_reg;
    assign stat.busy = busy_reg;
    assign stat.done = done_reg;

endmodule

FILE: rtl/cubic_interp_delay_line_top.sv
// a request runs ST_MUL, ST_CONV, ST_STEP, four memory reads in ST_READ, three chained
// multiplies in ST_M1..ST_M3 and ST_OUT, which waits for out_ready; a new delay at a
// block start adds ST_DIV for the slope divider; no new request is taken before ST_IDLE
// reset: control state cleared at once, memory cells never written read as zero
// (tracked by the write pointer and a wrap flag, so no clearing pass is needed)
module cubic_interp_delay_line_top
    import cid_pkg::*;
#(
    parameter int ADDR_BITS = ADDR_BITS_DEF,
    parameter int FRAC_BITS = FRAC_BITS_DEF
)
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       in_valid,
    output logic                       in_ready,
    input  logic signed [SAMPLE_W-1:0] sample_in,
    input  logic [SEC_W-1:0]           delay_seconds,
    input  logic                       block_start,
    output logic                       out_valid,
    input  logic                       out_ready,
    output logic signed [SAMPLE_W-1:0] sample_out,
    input  logic                       cfg_valid,
    output logic                       cfg_ready,
    input  logic [CFG_IDX_W-1:0]       cfg_index,
    input  logic [RATE_W-1:0]          cfg_data
);

    localparam int DW    = ADDR_BITS + FRAC_BITS + 1;
    localparam int PW    = SEC_W + RATE_W;
    localparam int SHIFT = SEC_FRAC - FRAC_BITS;
    localparam int FW    = FRAC_BITS + 1;
    localparam int CW_   = 28;
    localparam int BW    = 30;
    localparam int AW    = 31;
    localparam int YW    = 33;
    localparam int CFW   = CW_ + FW;
    localparam int BFW   = BW + FW;
    localparam int AFW   = AW + FW;
    localparam logic [DW-1:0] ONE_SAMPLE = DW'(1) << FRAC_BITS;
    localparam logic [DW-1:0] MAX_DELAY  = DW'(1) << (ADDR_BITS + FRAC_BITS);

    localparam logic [3:0] ST_IDLE = 4'd0;
    localparam logic [3:0] ST_MUL  = 4'd1;
    localparam logic [3:0] ST_CONV = 4'd2;
    localparam logic [3:0] ST_DIV  = 4'd3;
    localparam logic [3:0] ST_STEP = 4'd4;
    localparam logic [3:0] ST_READ = 4'd5;
    localparam logic [3:0] ST_M1   = 4'd6;
    localparam logic [3:0] ST_M2   = 4'd7;
    localparam logic [3:0] ST_M3   = 4'd8;
    localparam logic [3:0] ST_OUT  = 4'd9;

    logic [3:0]                 state_reg;
    logic [RATE_W-1:0]          rate_reg;
    logic [BLEN_W-1:0]          blen_reg;
    logic signed [SAMPLE_W-1:0] smp_reg;
    logic [SEC_W-1:0]           req_reg;
    logic                       bs_reg;
    logic [PW-1:0]              prod_reg;
    logic [DW-1:0]              cur_reg;
    logic [DW-1:0]              tgt_reg;
    logic signed [DW:0]         slope_reg;
    logic [BLEN_W-1:0]          ramp_reg;
    logic [SEC_W-1:0]           last_reg;
    logic                       started_reg;
    logic                       neg_reg;
    logic [ADDR_BITS-1:0]       wp_reg;
    logic                       wrapped_reg;
    logic [2:0]                 rd_cnt_reg;
    logic                       rd_pend_reg;
    logic                       rd_ok_reg;
    logic [1:0]                 rd_idx_reg;
    logic signed [SAMPLE_W-1:0] x_reg [4];
    logic signed [CFW-1:0]      cf_reg;
    logic signed [BFW-1:0]      bf_reg;
    logic signed [AFW-1:0]      af_reg;
    logic                       out_valid_reg;
    logic signed [SAMPLE_W-1:0] out_reg;

    logic [SAMPLE_W-1:0]        mem [2**ADDR_BITS];
    logic [SAMPLE_W-1:0]        mem_q;
    logic [ADDR_BITS-1:0]       rd_addr;
    logic                       mem_we;

    logic [PW-1:0]              shifted;
    logic [DW-1:0]              conv;
    logic [DW-1:0]              diff_mag;
    logic [BLEN_W-1:0]          bl_eff;
    logic                       div_start;
    logic [DW-1:0]              div_q;
    div_stat_t                  div_stat;
    logic signed [DW+1:0]       step_sum;
    logic signed [FW-1:0]       fs;
    logic signed [CW_-1:0]      c_val, em1c, e0c, e1c, e2c;
    logic signed [BW-1:0]       b_val, em1b, e0b, e1b, e2b;
    logic signed [AW-1:0]       a_val, em1a, e1a;
    logic signed [YW-1:0]       y_val;
    logic signed [SAMPLE_W-1:0] y_sat;
    logic                       out_free;

    cid_div #(.DW(DW)) u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (diff_mag),
        .divisor  (bl_eff),
        .quotient (div_q),
        .stat     (div_stat)
    );

    // seconds to samples, clamped to one sample .. memory size
    always_comb
    begin
        shifted = prod_reg >> SHIFT;
        if (shifted < PW'(ONE_SAMPLE))
            conv = ONE_SAMPLE;
        else if (shifted > PW'(MAX_DELAY))
            conv = MAX_DELAY;
        else
            conv = shifted[DW-1:0];
    end

    assign bl_eff    = (blen_reg == '0) ? BLEN_W'(1) : blen_reg;
    assign diff_mag  = (conv >= cur_reg) ? (conv - cur_reg) : (cur_reg - conv);
    assign div_start = (state_reg == ST_CONV) && bs_reg && started_reg && (req_reg != last_reg);
    assign step_sum  = signed'({2'b00, cur_reg}) + (DW+2)'(slope_reg);

    assign rd_addr = wp_reg - cur_reg[ADDR_BITS+FRAC_BITS-1:FRAC_BITS]
                     + ADDR_BITS'(rd_cnt_reg) - ADDR_BITS'(1);

    // interpolation datapath, one multiply per stage
    assign fs   = signed'({1'b0, cur_reg[FRAC_BITS-1:0]});
    assign em1c = CW_'(x_reg[0]);
    assign e0c  = CW_'(x_reg[1]);
    assign e1c  = CW_'(x_reg[2]);
    assign e2c  = CW_'(x_reg[3]);
    assign c_val = ((e0c - e1c) <<< 1) + (e0c - e1c) - em1c + e2c;

    assign em1b = BW'(x_reg[0]);
    assign e0b  = BW'(x_reg[1]);
    assign e1b  = BW'(x_reg[2]);
    assign e2b  = BW'(x_reg[3]);
    assign b_val = (e1b <<< 2) + (em1b <<< 1) - ((e0b <<< 2) + e0b) - e2b
                   + BW'(cf_reg >>> FRAC_BITS);

    assign em1a  = AW'(x_reg[0]);
    assign e1a   = AW'(x_reg[2]);
    assign a_val = e1a - em1a + AW'(bf_reg >>> FRAC_BITS);

    assign y_val = YW'(x_reg[1]) + YW'(af_reg >>> (FRAC_BITS + 1));

    always_comb
    begin
        if (y_val > YW'(8388607))
            y_sat = 24'sh7FFFFF;
        else if (y_val < -YW'(8388608))
            y_sat = 24'sh800000;
        else
            y_sat = y_val[SAMPLE_W-1:0];
    end

    assign out_free = !out_valid_reg || out_ready;
    assign mem_we   = (state_reg == ST_OUT) && out_free;

    always_ff @(posedge clk)
    begin
        if (mem_we)
            mem[wp_reg] <= smp_reg;
    end

    always_ff @(posedge clk)
    begin
        mem_q <= mem[rd_addr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rate_reg <= RATE_RESET;
            blen_reg <= BLEN_RESET;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                CFG_SAMPLE_RATE:  rate_reg <= cfg_data;
                CFG_BLOCK_LENGTH: blen_reg <= cfg_data[BLEN_W-1:0];
                default:          ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            cur_reg       <= ONE_SAMPLE;
            tgt_reg       <= ONE_SAMPLE;
            slope_reg     <= '0;
            ramp_reg      <= '0;
            last_reg      <= REQ_RESET;
            started_reg   <= 1'b0;
            wp_reg        <= '0;
            wrapped_reg   <= 1'b0;
            rd_cnt_reg    <= '0;
            rd_pend_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (mem_we)
                out_valid_reg <= 1'b1;
            else if (out_ready)
                out_valid_reg <= 1'b0;
            rd_pend_reg <= (state_reg == ST_READ) && (rd_cnt_reg != 3'd4);
            case (state_reg)
                ST_IDLE:
                begin
                    if (in_valid)
                        state_reg <= ST_MUL;
                end
                ST_MUL:
                begin
                    state_reg <= ST_CONV;
                end
                ST_CONV:
                begin
                    if (div_start)
                        state_reg <= ST_DIV;
                    else
                        state_reg <= ST_STEP;
                    if (bs_reg)
                    begin
                        if (!started_reg)
                        begin
                            started_reg <= 1'b1;
                            last_reg    <= req_reg;
                            cur_reg     <= conv;
                            tgt_reg     <= conv;
                            slope_reg   <= '0;
                            ramp_reg    <= '0;
                        end
                        else if (req_reg != last_reg)
                        begin
                            last_reg  <= req_reg;
                            tgt_reg   <= conv;
                            ramp_reg  <= bl_eff;
                        end
                    end
                end
                ST_DIV:
                begin
                    if (div_stat.done)
                    begin
                        slope_reg <= neg_reg ? -signed'({1'b0, div_q}) : signed'({1'b0, div_q});
                        state_reg <= ST_STEP;
                    end
                end
                ST_STEP:
                begin
                    if (ramp_reg != '0)
                    begin
                        if (ramp_reg == BLEN_W'(1))
                            cur_reg <= tgt_reg;
                        else
                            cur_reg <= step_sum[DW-1:0];
                        ramp_reg <= ramp_reg - 1'b1;
                    end
                    rd_cnt_reg <= '0;
                    state_reg  <= ST_READ;
                end
                ST_READ:
                begin
                    rd_cnt_reg <= rd_cnt_reg + 1'b1;
                    if (rd_cnt_reg == 3'd4)
                        state_reg <= ST_M1;
                end
                ST_M1:   state_reg <= ST_M2;
                ST_M2:   state_reg <= ST_M3;
                ST_M3:   state_reg <= ST_OUT;
                ST_OUT:
                begin
                    if (out_free)
                    begin
                        wp_reg        <= wp_reg + 1'b1;
                        if (wp_reg == '1)
                            wrapped_reg <= 1'b1;
                        state_reg     <= ST_IDLE;
                    end
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == ST_IDLE && in_valid)
        begin
            smp_reg <= sample_in;
            req_reg <= delay_seconds;
            bs_reg  <= block_start;
        end
        if (state_reg == ST_MUL)
            prod_reg <= PW'(req_reg) * PW'(rate_reg);
        if (div_start)
            neg_reg <= conv < cur_reg;
        // cells not yet written since reset read as zero
        rd_idx_reg <= rd_cnt_reg[1:0];
        rd_ok_reg  <= wrapped_reg || (rd_addr < wp_reg);
        if (rd_pend_reg)
            x_reg[rd_idx_reg] <= rd_ok_reg ? signed'(mem_q) : '0;
        if (state_reg == ST_M1)
            cf_reg <= CFW'(c_val) * CFW'(fs);
        if (state_reg == ST_M2)
            bf_reg <= BFW'(b_val) * BFW'(fs);
        if (state_reg == ST_M3)
            af_reg <= AFW'(a_val) * AFW'(fs);
        if (mem_we)
            out_reg <= y_sat;
    end

    assign in_ready   = (state_reg == ST_IDLE);
    assign cfg_ready  = 1'b1;
    assign out_valid  = out_valid_reg;
    assign sample_out = out_reg;

    a_cur_range: assert property (@(posedge clk) disable iff (!rst_n)
        (cur_reg >= ONE_SAMPLE) && (cur_reg <= MAX_DELAY))
        else $error("delay out of range");

    a_ramp_started: assert property (@(posedge clk) disable iff (!rst_n)
        (ramp_reg != '0) |-> started_reg)
        else $error("ramp before first block");

    a_div_done: assert property (@(posedge clk) disable iff (!rst_n)
        div_stat.done |-> (state_reg == ST_DIV))
        else $error("divider finished outside wait");

    a_write_once: assert property (@(posedge clk) disable iff (!rst_n)
        mem_we |=> (state_reg == ST_IDLE) && out_valid_reg)
        else $error("write without result");

endmodule
